// File: design/mhc_pkg.sv
package mhc_pkg;

	localparam int InWidth = 32;
	localparam int OutWidth = 8;
	localparam int CharWidth = 16;
	localparam int ClassWidth = 3;

	localparam logic [ClassWidth-1:0] CLS_REGULAR = 3'd0;
	localparam logic [ClassWidth-1:0] CLS_COMMENT = 3'd1;
	localparam logic [ClassWidth-1:0] CLS_MATH    = 3'd2;
	localparam logic [ClassWidth-1:0] CLS_COMMAND = 3'd3;
	localparam logic [ClassWidth-1:0] CLS_SPECIAL = 3'd4;

	localparam logic [CharWidth-1:0] CH_PERCENT   = 16'h0025;
	localparam logic [CharWidth-1:0] CH_BACKTICK  = 16'h0060;
	localparam logic [CharWidth-1:0] CH_BACKSLASH = 16'h005C;
	localparam logic [CharWidth-1:0] CH_LBRACE    = 16'h007B;
	localparam logic [CharWidth-1:0] CH_RBRACE    = 16'h007D;
	localparam logic [CharWidth-1:0] CH_DOLLAR    = 16'h0024;
	localparam logic [CharWidth-1:0] CH_NEWLINE   = 16'h000A;

	typedef struct packed {
		logic [ClassWidth-1:0] cls;
		logic                  math;
		logic                  disp;
		logic                  esc;
	} mhc_state_t;

	function automatic logic ascii_letter(input logic [CharWidth-1:0] c);
		return (c inside {[16'h0041:16'h005A], [16'h0061:16'h007A]});
	endfunction

endpackage

// File: design/mhc_step.sv
module mhc_step
	import mhc_pkg::*;
(
	input  logic [CharWidth-1:0] prev_char,
	input  logic [CharWidth-1:0] cur_char,
	input  mhc_state_t           cur_state,
	output mhc_state_t           next_state
);

	logic                  esc;
	logic                  tick;
	logic                  prev_tick;
	logic                  math;
	logic                  disp;
	logic                  was_cmd;
	logic [ClassWidth-1:0] cls;

	assign esc       = !cur_state.esc && (prev_char == CH_BACKSLASH);
	assign tick      = (cur_char == CH_BACKTICK) && !esc;
	assign prev_tick = (prev_char == CH_BACKTICK) && !cur_state.esc;
	assign was_cmd   = (cur_state.cls == CLS_COMMAND);

	always_comb begin
		math = cur_state.math;
		disp = cur_state.disp;
		cls  = CLS_REGULAR;
		if ((cur_char == CH_PERCENT && !esc) ||
		    (cur_state.cls == CLS_COMMENT && cur_char != CH_NEWLINE)) begin
			cls  = CLS_COMMENT;
			math = 1'b0;
			disp = 1'b0;
		end else begin
			// A second unescaped backtick right after the one that opened inline
			// math promotes it to display math.
			if (tick) begin
				if (math && prev_tick && !disp) begin
					disp = 1'b1;
				end else if (!math || prev_tick || !disp) begin
					math = !math;
				end
				if (!math) begin
					disp = 1'b0;
				end
			end
			cls = (tick || math) ? CLS_MATH : CLS_REGULAR;
			if (cls != CLS_MATH) begin
				if (cur_char == CH_BACKSLASH || was_cmd) begin
					cls = CLS_COMMAND;
				end
				if (was_cmd) begin
					if (ascii_letter(cur_char) &&
					    ((prev_char == CH_BACKSLASH && !cur_state.esc) ||
					     ascii_letter(prev_char))) begin
						cls = CLS_COMMAND;
					end else if (cur_char != CH_BACKSLASH &&
					             (!esc || (cur_char != CH_PERCENT &&
					                       cur_char != CH_BACKTICK))) begin
						cls = CLS_REGULAR;
					end
				end
				if (cls == CLS_REGULAR &&
				    (cur_char == CH_LBRACE || cur_char == CH_RBRACE ||
				     cur_char == CH_DOLLAR)) begin
					cls = CLS_SPECIAL;
				end
			end
		end
	end

	assign next_state.cls  = cls;
	assign next_state.math = math;
	assign next_state.disp = disp;
	assign next_state.esc  = esc;

endmodule

// File: design/markup_highlight_classifier_core.sv
// Character classifier for highlighting TeX-like markup text.
// The slave channel takes one request per character: the previous and the
// current 16-bit code unit. The master channel returns one result per request
// with the class (regular, comment, math, command, special) and the math,
// display-math and escape flags that hold after that character.
// A request accepted into the input register is classified from there, and its
// result is written into the result register that drives the master channel.
// One request is taken every cycle while the receiver keeps up: the
// classification is one level of compare logic on the input register and six
// state bits, written into the result register.
// When the receiver stalls, the result register holds and one more request is
// parked in the input register; s_tready drops only when both are full.
// Requests are processed strictly in order, and the state advances only when
// a request moves into the result register.
// Reset clears the classifier state to regular class with all flags low and
// empties both registers.
module markup_highlight_classifier_core
	import mhc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// prev_char [15:0], cur_char [31:16]
	input  logic [InWidth-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// char_class [2:0], in_math [3], in_display [4], escaped [5], zero [7:6]
	output logic [OutWidth-1:0] m_tdata
);

	logic                 valid_s1;
	logic [CharWidth-1:0] prev_s1;
	logic [CharWidth-1:0] cur_s1;
	logic                 advance;
	mhc_state_t           state_q;
	mhc_state_t           next_state;
	mhc_state_t           result_q;
	logic                 result_valid_q;

	assign advance  = !result_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			prev_s1 <= s_tdata[CharWidth-1:0];
			cur_s1  <= s_tdata[2*CharWidth-1:CharWidth];
		end
	end

	mhc_step u_step (
		.prev_char  (prev_s1),
		.cur_char   (cur_s1),
		.cur_state  (state_q),
		.next_state (next_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '{cls: CLS_REGULAR, math: 1'b0, disp: 1'b0, esc: 1'b0};
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= next_state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= next_state;
		end
	end

	assign m_tvalid = result_valid_q;
	assign m_tdata  = {2'b00, result_q.esc, result_q.disp, result_q.math, result_q.cls};

`ifndef SYNTHESIS
	a_disp_needs_math: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[4] || m_tdata[3]))
		else $error("display math flagged outside math mode");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= CLS_SPECIAL))
		else $error("unused class code produced");

	a_comment_no_math: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] == CLS_COMMENT) |-> (!m_tdata[3] && !m_tdata[4]))
		else $error("math flags set inside a comment");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> m_tvalid)
		else $error("processed request produced no result");
`endif

endmodule
